/* sv/crsam_pkg.sv */
// Shared types, constants and helpers for the CRTC screen address mapper.
package crsam_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned NUM_W   = 11;  // widest dividend (offset within a section)
    localparam int unsigned DEN_W   = 8;   // widest divisor (bytes per line)
    localparam int unsigned ADDR_W  = 4;

    localparam logic [1:0] REG_DISPLAY_START = 2'd0;
    localparam logic [1:0] REG_CHAR_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHARS_DISP    = 2'd2;

    localparam logic [13:0] DISPLAY_START_RST = 14'd12288;
    localparam logic [4:0]  CHAR_HEIGHT_RST   = 5'd7;
    localparam logic [7:0]  CHARS_DISP_RST    = 8'd40;

    localparam logic [15:0] BANK_SIZE       = 16'h4000;
    localparam logic [15:0] BIG_SCREEN_SIZE = 16'h8000;
    localparam logic [15:0] SECTION_SIZE    = 16'd2048;

    typedef struct packed {
        logic [13:0] display_start;
        logic [4:0]  char_height_minus_one;
        logic [7:0]  chars_displayed;
    } cfg_t;

    // one queued beat, already classified by the front end
    typedef struct packed {
        logic              op;
        logic              ok;
        logic [7:0]        xq;
        logic [4:0]        line;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } item_t;

    typedef struct packed {
        logic              op;
        logic              ok;
        logic [7:0]        xq;
        logic [4:0]        line;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quo;
    } div_t;

    function automatic logic [15:0] screen_start(cfg_t c);
        return {c.display_start[13:12], 3'b000, c.display_start[9:0], 1'b0};
    endfunction

    function automatic logic [7:0] bytes_per_line(cfg_t c);
        return {c.chars_displayed[6:0], 1'b0};
    endfunction

    // one restoring division step
    function automatic div_t div_step(div_t s);
        div_t             r;
        logic [DEN_W:0]   t;
        logic             ge;
        r  = s;
        t  = {s.rem, s.num[NUM_W-1]};
        ge = (t >= {1'b0, s.den});
        r.rem = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
        r.num = {s.num[NUM_W-2:0], 1'b0};
        r.quo = {s.quo[NUM_W-2:0], ge};
        return r;
    endfunction

endpackage

/* sv/crtc_screen_address_mapper.sv */
// Path from input beat to result beat: queue, divider stages, multiply stage, output register.
// Throughput: one beat per cycle while the output is not stalled; the 11-step restoring divider is fully pipelined.
// A full output stalls the whole back end; the queue keeps taking beats until full.
// Reset (rst_n, async, active low) empties queue and pipeline and loads register
// defaults: display_start 12288, char_height_minus_one 7, chars_displayed 40.
module crtc_screen_address_mapper
    import crsam_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [9:0]         x_in,
    input  logic [8:0]         y_in,
    input  logic [15:0]        addr_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic [15:0]        addr_out,
    output logic [9:0]         x_out,
    output logic [14:0]        y_out
);
    cfg_t   cfg_reg;
    item_t  f_item, q_item;
    logic   q_full, q_ne, q_pop, wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_start         <= DISPLAY_START_RST;
            cfg_reg.char_height_minus_one <= CHAR_HEIGHT_RST;
            cfg_reg.chars_displayed       <= CHARS_DISP_RST;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_DISPLAY_START: cfg_reg.display_start         <= pwdata[13:0];
                REG_CHAR_HEIGHT:   cfg_reg.char_height_minus_one <= pwdata[4:0];
                REG_CHARS_DISP:    cfg_reg.chars_displayed       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DISPLAY_START: prdata = {18'b0, cfg_reg.display_start};
            REG_CHAR_HEIGHT:   prdata = {27'b0, cfg_reg.char_height_minus_one};
            REG_CHARS_DISP:    prdata = {24'b0, cfg_reg.chars_displayed};
            default:           prdata = '0;
        endcase
    end

    crsam_front u_front (
        .cfg(cfg_reg), .opcode(opcode), .x_in(x_in), .y_in(y_in),
        .addr_in(addr_in), .item(f_item)
    );

    assign in_ready = !q_full;

    crsam_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(in_valid), .push_data(f_item),
        .full(q_full), .pop(q_pop), .not_empty(q_ne), .pop_data(q_item)
    );

    crsam_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_valid(q_ne), .q_data(q_item),
        .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
        .valid_res(valid_res), .addr_out(addr_out), .x_out(x_out), .y_out(y_out)
    );
endmodule

/* sv/crsam_front.sv */
// Front end: window check and classification of one input beat.
module crsam_front
    import crsam_pkg::*;
(
    input  cfg_t         cfg,
    input  logic         opcode,
    input  logic [9:0]   x_in,
    input  logic [8:0]   y_in,
    input  logic [15:0]  addr_in,
    output item_t        item
);
    logic [15:0] start;
    logic [15:0] size;
    logic [15:0] win_end;
    logic [15:0] tot;
    logic [7:0]  bpl;

    always_comb
    begin
        start   = screen_start(cfg);
        bpl     = bytes_per_line(cfg);
        size    = (cfg.display_start[11:10] == 2'b11) ? BIG_SCREEN_SIZE : BANK_SIZE;
        win_end = start + size - 16'd1;
        tot     = addr_in - start;
        item.op = opcode;
        item.xq = x_in[9:2];
        if (opcode == 1'b0)
        begin
            item.ok   = 1'b1;
            item.line = '0;
            item.num  = NUM_W'(y_in);
            item.den  = DEN_W'({1'b0, cfg.char_height_minus_one} + 6'd1);
        end
        else
        begin
            item.ok   = (addr_in >= start) && (addr_in <= win_end) && (bpl != 8'd0);
            item.line = tot[15:11];
            item.num  = tot[10:0];
            item.den  = bpl;
        end
    end
endmodule

/* sv/crsam_fifo.sv */
// Short queue between front end and back end.
module crsam_fifo
    import crsam_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output item_t  pop_data
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (do_pop)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= push_data;
    end
endmodule

/* sv/crsam_back.sv */
// Back end: pipelined divider, multiply stage and output register.
module crsam_back
    import crsam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  item_t        q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         valid_res,
    output logic [15:0]  addr_out,
    output logic [9:0]   x_out,
    output logic [14:0]  y_out
);
    localparam int unsigned STEPS = NUM_W;

    div_t         stg_reg [STEPS+1];
    logic         sv_reg  [STEPS+1];
    div_t         mul_reg;
    logic         mv_reg;
    logic [15:0]  prod_reg, prod_next;
    logic         ov_reg;
    logic         vr_reg, vr_next;
    logic [15:0]  ao_reg, ao_next;
    logic [9:0]   xo_reg, xo_next;
    logic [14:0]  yo_reg, yo_next;
    logic         adv;
    logic [15:0]  start, off, addr;
    logic [7:0]   mul_b;

    assign adv   = !ov_reg || out_ready;
    assign q_pop = adv;

    always_comb
    begin
        mul_b     = stg_reg[STEPS].op ? {2'b00, 6'({1'b0, cfg.char_height_minus_one} + 6'd1)}
                                      : bytes_per_line(cfg);
        prod_next = {5'b0, stg_reg[STEPS].quo} * {8'b0, mul_b};
    end

    // row and line: quotient and remainder for addresses, section index for coordinates
    always_comb
    begin
        start   = screen_start(cfg);
        off     = prod_reg + {mul_reg.rem[4:0], 11'b0} + {8'b0, mul_reg.xq};
        addr    = start + off;
        if ((cfg.display_start[9:0] != 10'd0) && ({3'b0, addr[10:0]} < start[13:0]))
            addr = addr - SECTION_SIZE;
        vr_next = 1'b0;
        ao_next = '0;
        xo_next = '0;
        yo_next = '0;
        if (mul_reg.op == 1'b0)
        begin
            vr_next = 1'b1;
            ao_next = addr;
        end
        else if (mul_reg.ok)
        begin
            vr_next = 1'b1;
            xo_next = {mul_reg.rem, 2'b00};
            yo_next = prod_reg[14:0] + {10'b0, mul_reg.line};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
                sv_reg[i] <= 1'b0;
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= q_valid;
            for (int i = 0; i < STEPS; i++)
                sv_reg[i+1] <= sv_reg[i];
            mv_reg <= sv_reg[STEPS];
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0].op   <= q_data.op;
            stg_reg[0].ok   <= q_data.ok;
            stg_reg[0].xq   <= q_data.xq;
            stg_reg[0].line <= q_data.line;
            stg_reg[0].den  <= q_data.den;
            stg_reg[0].rem  <= '0;
            stg_reg[0].num  <= q_data.num;
            stg_reg[0].quo  <= '0;
            for (int i = 0; i < STEPS; i++)
                stg_reg[i+1] <= div_step(stg_reg[i]);
            mul_reg  <= stg_reg[STEPS];
            prod_reg <= prod_next;
            vr_reg   <= vr_next;
            ao_reg   <= ao_next;
            xo_reg   <= xo_next;
            yo_reg   <= yo_next;
        end
    end

    assign out_valid = ov_reg;
    assign valid_res = vr_reg;
    assign addr_out  = ao_reg;
    assign x_out     = xo_reg;
    assign y_out     = yo_reg;
endmodule

/* sv/crsam_checker.sv */
// Port-level checker for the screen address mapper, bound to the top level.
module crsam_checker
    import crsam_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic         valid_res,
    input  logic [15:0]  addr_out,
    input  logic [9:0]   x_out,
    input  logic [14:0]  y_out
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(addr_out) && $stable(y_out))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> addr_out == 16'd0 && x_out == 10'd0 && y_out == 15'd0)
        else $error("invalid result carries data");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && addr_out != 16'd0 |-> x_out == 10'd0 && y_out == 15'd0)
        else $error("address and coordinates both set");

    a_x_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> x_out[1:0] == 2'b00)
        else $error("column not byte aligned");
endmodule

bind crtc_screen_address_mapper crsam_checker u_crsam_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .valid_res(valid_res), .addr_out(addr_out), .x_out(x_out), .y_out(y_out)
);
